>>> rtl/core/ntmb_pkg.sv
// ----------------------------------------------------------------------------
// ntmb_pkg
// Shared widths, command codes and scan control type for the nearest
// timestamp match buffer.
// ----------------------------------------------------------------------------
package ntmb_pkg;

	localparam int TIME_W = 62;
	localparam int SRC_W  = 16;
	localparam int CMD_W  = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MATCH = 2'd2;

	localparam logic [TIME_W-1:0] MAX_DELTA_RESET = 62'd50000000;
	localparam logic [TIME_W-1:0] MAX_AGE_RESET   = 62'd500000000;

	localparam logic REG_MAX_DELTA = 1'b0;
	localparam logic REG_MAX_AGE   = 1'b1;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [SRC_W-1:0]  src_t;

	typedef struct packed {
		logic init;
		logic en;
		logic live;
	} scan_ctl_t;

endpackage

>>> rtl/core/ntmb_cell.sv
// ----------------------------------------------------------------------------
// ntmb_cell
// One history slot of the shift chain: takes its neighbor's record when the
// chain advances, otherwise holds.
// ----------------------------------------------------------------------------
module ntmb_cell #(
	parameter int HANDLE_W = 16
) (
	input  logic                 clk,
	input  logic                 shift,
	input  ntmb_pkg::time_t      stamp_in,
	input  ntmb_pkg::time_t      capture_in,
	input  ntmb_pkg::src_t       source_in,
	input  logic [HANDLE_W-1:0]  handle_in,
	output ntmb_pkg::time_t      stamp_out,
	output ntmb_pkg::time_t      capture_out,
	output ntmb_pkg::src_t       source_out,
	output logic [HANDLE_W-1:0]  handle_out
);
	import ntmb_pkg::*;

	time_t               stamp_q;
	time_t               capture_q;
	src_t                source_q;
	logic [HANDLE_W-1:0] handle_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			stamp_q   <= stamp_in;
			capture_q <= capture_in;
			source_q  <= source_in;
			handle_q  <= handle_in;
		end
	end

	assign stamp_out   = stamp_q;
	assign capture_out = capture_q;
	assign source_out  = source_q;
	assign handle_out  = handle_q;

endmodule

>>> rtl/core/ntmb_scan.sv
// ----------------------------------------------------------------------------
// ntmb_scan
// Two-stage compare unit at the end of the chain: qualifies one record per
// cycle and keeps the closest stamp seen so far, later records winning ties.
// ----------------------------------------------------------------------------
module ntmb_scan #(
	parameter int HANDLE_W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ntmb_pkg::scan_ctl_t  ctl,
	input  ntmb_pkg::time_t      e_stamp,
	input  ntmb_pkg::time_t      e_capture,
	input  ntmb_pkg::src_t       e_source,
	input  logic [HANDLE_W-1:0]  e_handle,
	input  ntmb_pkg::time_t      q_stamp,
	input  ntmb_pkg::time_t      q_now,
	input  ntmb_pkg::src_t       q_source,
	input  ntmb_pkg::time_t      max_delta,
	input  ntmb_pkg::time_t      max_age,
	output logic                 hit,
	output logic [HANDLE_W-1:0]  best_handle,
	output ntmb_pkg::time_t      best_delta
);
	import ntmb_pkg::*;

	logic [TIME_W:0]     diff_fwd;
	logic [TIME_W:0]     age_full;
	time_t               delta;
	logic                age_ok;

	logic                valid_s1;
	logic                cand_s1;
	time_t               delta_s1;
	logic [HANDLE_W-1:0] handle_s1;

	logic                hit_q;
	time_t               best_delta_q;
	logic [HANDLE_W-1:0] best_handle_q;

	always_comb begin
		diff_fwd = {1'b0, q_stamp} - {1'b0, e_stamp};
		delta    = diff_fwd[TIME_W] ? (e_stamp - q_stamp) : diff_fwd[TIME_W-1:0];
		age_full = {1'b0, q_now} - {1'b0, e_capture};
		age_ok   = !age_full[TIME_W] && (age_full[TIME_W-1:0] <= max_age);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.en;
		end
	end

	always_ff @(posedge clk) begin
		cand_s1   <= ctl.live && (e_source == q_source) && age_ok;
		delta_s1  <= delta;
		handle_s1 <= e_handle;
	end

	// running best, reloaded when a query starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.init) begin
			hit_q <= 1'b0;
		end else if (valid_s1 && cand_s1 && (delta_s1 <= best_delta_q)) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			best_delta_q  <= max_delta;
			best_handle_q <= '0;
		end else if (valid_s1 && cand_s1 && (delta_s1 <= best_delta_q)) begin
			best_delta_q  <= delta_s1;
			best_handle_q <= handle_s1;
		end
	end

	assign hit         = hit_q;
	assign best_handle = best_handle_q;
	assign best_delta  = best_delta_q;

endmodule

>>> rtl/core/nearest_timestamp_match_buffer_core.sv
// ----------------------------------------------------------------------------
// nearest_timestamp_match_buffer_core
// History of sensor frame records with nearest-stamp lookup per source.
// ----------------------------------------------------------------------------
// Input words (in_valid / in_stall) carry a command: push a frame record,
// clear the history, or match a query against the stored records. Only a
// match produces an output word (out_valid / out_stall) with found, the
// chosen handle and its stamp difference.
// Records live in a chain of HISTORY_DEPTH cells, newest at the head. A push
// shifts the chain as it is accepted, so pushes and clears are taken back to
// back. A match rotates the whole chain once past a two-stage compare unit
// at the tail, one record per cycle; the machine then steps through flush
// and done, loads the result into the output register and goes idle, where
// the next word is taken. When the receiver stalls, the result holds in the
// output register; a further match finishes its scan and then waits for that
// register to free. Pushes are stalled meanwhile. Reset empties the history
// and loads the default max_delta_ns and max_age_ns; the user must write both
// registers through the cfg port only while no match is in flight, which the
// block itself does not enforce.
// ----------------------------------------------------------------------------
module nearest_timestamp_match_buffer_core #(
	parameter int HISTORY_DEPTH = 32,
	parameter int HANDLE_WIDTH  = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  ntmb_pkg::time_t          cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [ntmb_pkg::CMD_W-1:0] command,
	input  ntmb_pkg::time_t          stamp_ns,
	input  ntmb_pkg::time_t          capture_ns,
	input  ntmb_pkg::time_t          now_ns,
	input  ntmb_pkg::src_t           source_id,
	input  logic [HANDLE_WIDTH-1:0]  frame_handle,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     found,
	output logic [HANDLE_WIDTH-1:0]  match_handle,
	output ntmb_pkg::time_t          match_delta_ns
);
	import ntmb_pkg::*;

	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int STEP_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]          state_q;
	logic [STEP_W-1:0]   step_q;
	logic [CNT_W-1:0]    count_q;
	time_t               max_delta_q;
	time_t               max_age_q;
	time_t               q_stamp_q;
	time_t               q_now_q;
	src_t                q_source_q;

	logic                out_valid_q;
	logic                found_q;
	logic [HANDLE_WIDTH-1:0] match_handle_q;
	time_t               match_delta_q;

	logic                accept;
	logic                push;
	logic                scanning;
	logic                shift;
	logic                last_step;
	logic                load_out;
	logic [CNT_W:0]      live_sum;
	scan_ctl_t           scan_ctl;

	time_t               c_stamp   [HISTORY_DEPTH];
	time_t               c_capture [HISTORY_DEPTH];
	src_t                c_source  [HISTORY_DEPTH];
	logic [HANDLE_WIDTH-1:0] c_handle [HISTORY_DEPTH];

	time_t               head_stamp;
	time_t               head_capture;
	src_t                head_source;
	logic [HANDLE_WIDTH-1:0] head_handle;

	logic                hit;
	logic [HANDLE_WIDTH-1:0] best_handle;
	time_t               best_delta;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign push      = accept && (command == CMD_PUSH);
	assign scanning  = (state_q == ST_SCAN);
	assign shift     = push || scanning;
	assign last_step = (step_q == STEP_W'(HISTORY_DEPTH - 1));
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign live_sum  = {{(CNT_W + 1 - STEP_W){1'b0}}, step_q} + {1'b0, count_q};

	// the head takes the new word on a push, the tail word while rotating
	always_comb begin
		if (scanning) begin
			head_stamp   = c_stamp[HISTORY_DEPTH-1];
			head_capture = c_capture[HISTORY_DEPTH-1];
			head_source  = c_source[HISTORY_DEPTH-1];
			head_handle  = c_handle[HISTORY_DEPTH-1];
		end else begin
			head_stamp   = stamp_ns;
			head_capture = capture_ns;
			head_source  = source_id;
			head_handle  = frame_handle;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < HISTORY_DEPTH; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				ntmb_cell #(.HANDLE_W(HANDLE_WIDTH)) u_cell (
					.clk         (clk),
					.shift       (shift),
					.stamp_in    (head_stamp),
					.capture_in  (head_capture),
					.source_in   (head_source),
					.handle_in   (head_handle),
					.stamp_out   (c_stamp[gi]),
					.capture_out (c_capture[gi]),
					.source_out  (c_source[gi]),
					.handle_out  (c_handle[gi])
				);
			end else begin : g_body
				ntmb_cell #(.HANDLE_W(HANDLE_WIDTH)) u_cell (
					.clk         (clk),
					.shift       (shift),
					.stamp_in    (c_stamp[gi-1]),
					.capture_in  (c_capture[gi-1]),
					.source_in   (c_source[gi-1]),
					.handle_in   (c_handle[gi-1]),
					.stamp_out   (c_stamp[gi]),
					.capture_out (c_capture[gi]),
					.source_out  (c_source[gi]),
					.handle_out  (c_handle[gi])
				);
			end
		end
	endgenerate

	always_comb begin
		scan_ctl.init = accept && (command == CMD_MATCH);
		scan_ctl.en   = scanning;
		scan_ctl.live = (live_sum >= (CNT_W + 1)'(HISTORY_DEPTH));
	end

	ntmb_scan #(.HANDLE_W(HANDLE_WIDTH)) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (scan_ctl),
		.e_stamp     (c_stamp[HISTORY_DEPTH-1]),
		.e_capture   (c_capture[HISTORY_DEPTH-1]),
		.e_source    (c_source[HISTORY_DEPTH-1]),
		.e_handle    (c_handle[HISTORY_DEPTH-1]),
		.q_stamp     (q_stamp_q),
		.q_now       (q_now_q),
		.q_source    (q_source_q),
		.max_delta   (max_delta_q),
		.max_age     (max_age_q),
		.hit         (hit),
		.best_handle (best_handle),
		.best_delta  (best_delta)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_delta_q <= MAX_DELTA_RESET;
			max_age_q   <= MAX_AGE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_DELTA: max_delta_q <= cfg_data;
				REG_MAX_AGE:   max_age_q   <= cfg_data;
				default:       max_age_q   <= max_age_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (accept) begin
						case (command)
							CMD_PUSH: begin
								if ((count_q != '0) && (stamp_ns <= c_stamp[0])) begin
									count_q <= CNT_W'(1);
								end else if (count_q != CNT_W'(HISTORY_DEPTH)) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_CLEAR: count_q <= '0;
							CMD_MATCH: state_q <= ST_SCAN;
							default:   count_q <= count_q;
						endcase
					end
				end
				ST_SCAN: begin
					step_q <= step_q + STEP_W'(1);
					if (last_step) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (scan_ctl.init) begin
			q_stamp_q  <= stamp_ns;
			q_now_q    <= now_ns;
			q_source_q <= source_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			found_q        <= hit;
			match_handle_q <= hit ? best_handle : '0;
			match_delta_q  <= hit ? best_delta : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign match_handle   = match_handle_q;
	assign match_delta_ns = match_delta_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(HISTORY_DEPTH))
		else $error("history count above depth");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result word raised outside the done state");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> match_handle_q == '0 && match_delta_q == '0)
		else $error("miss word with nonzero handle or delta");

	a_match_busy: assert property (@(posedge clk) disable iff (!arst_n)
		scan_ctl.init |=> in_stall && state_q == ST_SCAN)
		else $error("match accepted without starting a scan");

endmodule
